// ----- rtl/core/reliable_link_stop_and_wait_defines.svh -----
// Assertion macros used by the checker file.
`ifndef RELIABLE_LINK_STOP_AND_WAIT_DEFINES_SVH
`define RELIABLE_LINK_STOP_AND_WAIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define RLSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RLSW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/rlsw_pkg.sv -----
`timescale 1ns / 1ps

package rlsw_pkg;

  localparam int unsigned SEQ_W   = 7;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned MAX_RES = 3;

  localparam logic [LEN_W-1:0] INFO_HDR_LEN = 16'd6;
  localparam logic [LEN_W-1:0] SUP_HDR_LEN  = 16'd2;
  localparam logic [3:0]       RETRY_SAT    = 4'd15;

  localparam logic [3:0]  RST_RETRY_LIMIT        = 4'd10;
  localparam logic [15:0] RST_RETRANSMIT_TIMEOUT = 16'd200;

  // configuration register indexes
  localparam logic REG_RETRY_LIMIT        = 1'b0;
  localparam logic REG_RETRANSMIT_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    OP_CMD_RX   = 3'd0,
    OP_RSP_RX   = 3'd1,
    OP_TIMER    = 3'd2,
    OP_SEND     = 3'd3,
    OP_LINK_UP  = 3'd4,
    OP_LINK_DN  = 3'd5
  } rlsw_op_t;

  typedef enum logic [3:0] {
    ACT_NONE    = 4'd0,
    ACT_CANCEL  = 4'd1,
    ACT_RELEASE = 4'd2,
    ACT_RR      = 4'd3,
    ACT_DELIVER = 4'd4,
    ACT_START   = 4'd5,
    ACT_INFO    = 4'd6,
    ACT_BOUNCE  = 4'd7,
    ACT_REFUSED = 4'd8,
    ACT_TOOBIG  = 4'd9
  } rlsw_act_t;

  typedef struct packed {
    logic [2:0]       operation;
    logic             hdr_supervisory;
    logic             hdr_poll;
    logic [SEQ_W-1:0] hdr_seq;
    logic [SEQ_W-1:0] hdr_ack;
    logic [LEN_W-1:0] hdr_length;
    logic [LEN_W-1:0] byte_count;
    logic [SEQ_W-1:0] timer_seq;
    logic [LEN_W-1:0] frame_protocol;
  } rlsw_item_t;

  typedef struct packed {
    rlsw_act_t        action;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] ack;
    logic             poll_final;
    logic [LEN_W-1:0] protocol;
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] timeout;
    logic             last;
  } rlsw_res_t;

endpackage

// ----- rtl/core/reliable_link_stop_and_wait.sv -----
`timescale 1ns / 1ps
// Stop-and-wait link layer (one outstanding info packet, modulo-128 numbering).
// Input channel: in_valid / in_stall carry one event transaction (received
//   command or response header, timer expiry, send request, layer up/down).
// Output channel: out_valid / out_stall carry action transactions, 0 to 3 per
//   event, in order; last marks the final action of an event. Events that
//   cause no action produce no output transaction.
// Configuration: APB-style port, retry_limit at 0x0, retransmit_timeout
//   at 0x4; write only while the block is idle.
// Flow: an event is registered at acceptance and evaluated from that register;
//   its actions are written together to a 4-entry result queue, whose head
//   drives the output channel.
// Throughput: one event per cycle while the queue has room for all of that
//   event's actions; the queue drains one action per cycle while out_stall
//   is low.
// Stall: while out_stall is high the head action holds; the queue fills and
//   in_stall rises when the registered event no longer fits.
// Reset (rst, synchronous): link down, V(S)=V(R)=0, retry count and busy flag
//   cleared, queue emptied, registers back to 10 and 200 ms.
module reliable_link_stop_and_wait #(
  parameter int unsigned MAX_INFO_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic        hdr_supervisory,
  input  logic [1:0]  hdr_kind,
  input  logic        hdr_poll,
  input  logic [6:0]  hdr_seq,
  input  logic [6:0]  hdr_ack,
  input  logic [15:0] hdr_length,
  input  logic [15:0] byte_count,
  input  logic [6:0]  timer_seq,
  input  logic [15:0] frame_protocol,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  action,
  output logic [6:0]  out_seq,
  output logic [6:0]  out_ack,
  output logic        out_poll_final,
  output logic [15:0] out_protocol,
  output logic [15:0] out_length,
  output logic [15:0] out_timeout,
  output logic        last,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [15:0] MaxInfoLen = 16'(MAX_INFO_LEN);

  // ---------------------------------------------------------------- config
  logic [3:0]  retry_limit;
  logic [15:0] retransmit_timeout;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit        <= rlsw_pkg::RST_RETRY_LIMIT;
      retransmit_timeout <= rlsw_pkg::RST_RETRANSMIT_TIMEOUT;
    end else if (cfg_wr) begin
      if (paddr[2] == rlsw_pkg::REG_RETRY_LIMIT) begin
        retry_limit <= pwdata[3:0];
      end else begin
        retransmit_timeout <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == rlsw_pkg::REG_RETRY_LIMIT) begin
      prdata = {28'd0, retry_limit};
    end else begin
      prdata = {16'd0, retransmit_timeout};
    end
  end

  // ---------------------------------------------------------------- input register
  rlsw_pkg::rlsw_item_t item;
  logic                 item_valid;
  logic                 advance;
  logic                 in_take;

  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // hdr_kind is ignored: every supervisory kind acts as RR
  always_ff @(posedge clk) begin
    if (in_take) begin
      item.operation       <= operation;
      item.hdr_supervisory <= hdr_supervisory;
      item.hdr_poll        <= hdr_poll ^ (hdr_kind[0] & 1'b0);
      item.hdr_seq         <= hdr_seq;
      item.hdr_ack         <= hdr_ack;
      item.hdr_length      <= hdr_length;
      item.byte_count      <= byte_count;
      item.timer_seq       <= timer_seq;
      item.frame_protocol  <= frame_protocol;
    end
  end

  // ---------------------------------------------------------------- link state
  logic        link_up,       link_up_next;
  logic [6:0]  send_var,      send_var_next;
  logic [6:0]  recv_var,      recv_var_next;
  logic [3:0]  retry_count,   retry_count_next;
  logic        tx_busy,       tx_busy_next;
  logic [15:0] held_protocol, held_protocol_next;
  logic [15:0] held_length,   held_length_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_up       <= 1'b0;
      send_var      <= '0;
      recv_var      <= '0;
      retry_count   <= '0;
      tx_busy       <= 1'b0;
      held_protocol <= '0;
      held_length   <= '0;
    end else if (advance) begin
      link_up       <= link_up_next;
      send_var      <= send_var_next;
      recv_var      <= recv_var_next;
      retry_count   <= retry_count_next;
      tx_busy       <= tx_busy_next;
      held_protocol <= held_protocol_next;
      held_length   <= held_length_next;
    end
  end

  // ---------------------------------------------------------------- event evaluation
  rlsw_pkg::rlsw_res_t res [rlsw_pkg::MAX_RES];
  logic [1:0]          res_n;
  logic                ack_hit;
  logic                short_sup;
  logic                short_info;
  logic [3:0]          retry_inc;
  logic [6:0]          recv_inc;

  // N(R) acknowledges the outstanding packet when N(R)-1 == V(S), mod 128
  assign ack_hit    = (item.hdr_ack - 7'd1) == send_var;
  assign short_sup  = item.byte_count < rlsw_pkg::SUP_HDR_LEN;
  assign short_info = item.byte_count < rlsw_pkg::INFO_HDR_LEN;
  assign retry_inc  = (retry_count < rlsw_pkg::RETRY_SAT) ? retry_count + 4'd1 : retry_count;
  assign recv_inc   = recv_var + 7'd1;

  always_comb begin
    for (int i = 0; i < rlsw_pkg::MAX_RES; i++) begin
      res[i] = '0;
    end
    res_n              = 2'd0;
    link_up_next       = link_up;
    send_var_next      = send_var;
    recv_var_next      = recv_var;
    retry_count_next   = retry_count;
    tx_busy_next       = tx_busy;
    held_protocol_next = held_protocol;
    held_length_next   = held_length;

    unique case (item.operation)
      rlsw_pkg::OP_CMD_RX, rlsw_pkg::OP_RSP_RX: begin
        if (link_up) begin
          if (short_sup || (item.operation == rlsw_pkg::OP_CMD_RX &&
                            !item.hdr_supervisory && short_info)) begin
            // runt frame: bounce the link
            res[0].action = rlsw_pkg::ACT_CANCEL;
            res[1].action = rlsw_pkg::ACT_BOUNCE;
            res_n         = 2'd2;
            link_up_next  = 1'b0;
            tx_busy_next  = 1'b0;
          end else if (item.hdr_supervisory) begin
            if (ack_hit) begin
              res[0].action    = rlsw_pkg::ACT_CANCEL;
              res[1].action    = rlsw_pkg::ACT_RELEASE;
              res_n            = 2'd2;
              retry_count_next = '0;
              send_var_next    = send_var + 7'd1;
              tx_busy_next     = 1'b0;
            end
            // a polled supervisory command gets an RR with final set
            if (item.operation == rlsw_pkg::OP_CMD_RX && item.hdr_poll) begin
              if (ack_hit) begin
                res[2].action     = rlsw_pkg::ACT_RR;
                res[2].ack        = recv_var;
                res[2].poll_final = 1'b1;
                res_n             = 2'd3;
              end else begin
                res[0].action     = rlsw_pkg::ACT_RR;
                res[0].ack        = recv_var;
                res[0].poll_final = 1'b1;
                res_n             = 2'd1;
              end
            end
          end else if (item.operation == rlsw_pkg::OP_CMD_RX) begin
            // info command; info responses are dropped
            if (item.hdr_seq == recv_var) begin
              recv_var_next = recv_inc;
              // truncated packet: V(R) still advances, nothing emitted
              if (item.hdr_length <= item.byte_count) begin
                res[0].action   = rlsw_pkg::ACT_DELIVER;
                res[0].protocol = item.frame_protocol;
                res[0].length   = (item.hdr_length >= rlsw_pkg::INFO_HDR_LEN) ?
                                  item.hdr_length - rlsw_pkg::INFO_HDR_LEN : '0;
                res[1].action     = rlsw_pkg::ACT_RR;
                res[1].ack        = recv_inc;
                res[1].poll_final = item.hdr_poll;
                res_n             = 2'd2;
              end
            end else begin
              res[0].action     = rlsw_pkg::ACT_RR;
              res[0].ack        = recv_var;
              res[0].poll_final = item.hdr_poll;
              res_n             = 2'd1;
            end
          end
        end
      end
      rlsw_pkg::OP_TIMER: begin
        // stale expiries are ignored; honored even with the link down
        if (item.timer_seq == send_var) begin
          retry_count_next = retry_inc;
          if (retry_inc < retry_limit) begin
            res[0].action     = rlsw_pkg::ACT_INFO;
            res[0].seq        = item.timer_seq;
            res[0].ack        = recv_var;
            res[0].poll_final = 1'b1;
            res[0].protocol   = held_protocol;
            res[0].length     = held_length + rlsw_pkg::INFO_HDR_LEN;
            res[1].action     = rlsw_pkg::ACT_START;
            res[1].seq        = item.timer_seq;
            res[1].timeout    = retransmit_timeout;
          end else begin
            res[0].action = rlsw_pkg::ACT_CANCEL;
            res[1].action = rlsw_pkg::ACT_BOUNCE;
            link_up_next  = 1'b0;
            tx_busy_next  = 1'b0;
          end
          res_n = 2'd2;
        end
      end
      rlsw_pkg::OP_SEND: begin
        if (!link_up || tx_busy) begin
          res[0].action = rlsw_pkg::ACT_REFUSED;
          res_n         = 2'd1;
        end else if (item.byte_count > MaxInfoLen) begin
          res[0].action = rlsw_pkg::ACT_TOOBIG;
          res_n         = 2'd1;
        end else begin
          tx_busy_next       = 1'b1;
          held_protocol_next = item.frame_protocol;
          held_length_next   = item.byte_count;
          res[0].action      = rlsw_pkg::ACT_START;
          res[0].seq         = send_var;
          res[0].timeout     = retransmit_timeout;
          res[1].action      = rlsw_pkg::ACT_INFO;
          res[1].seq         = send_var;
          res[1].ack         = recv_var;
          res[1].poll_final  = 1'b1;
          res[1].protocol    = item.frame_protocol;
          res[1].length      = item.byte_count + rlsw_pkg::INFO_HDR_LEN;
          res_n              = 2'd2;
        end
      end
      rlsw_pkg::OP_LINK_UP: begin
        link_up_next     = 1'b1;
        send_var_next    = '0;
        recv_var_next    = '0;
        retry_count_next = '0;
        tx_busy_next     = 1'b0;
        res[0].action    = rlsw_pkg::ACT_RELEASE;
        res_n            = 2'd1;
      end
      rlsw_pkg::OP_LINK_DN: begin
        res[0].action = rlsw_pkg::ACT_CANCEL;
        res[1].action = rlsw_pkg::ACT_RELEASE;
        res_n         = 2'd2;
        link_up_next  = 1'b0;
        tx_busy_next  = 1'b0;
      end
      default: begin
        // undefined operation codes: no action, no state change
      end
    endcase

    for (int i = 0; i < rlsw_pkg::MAX_RES; i++) begin
      res[i].last = (res_n == 2'(i + 1));
    end
  end

  // ---------------------------------------------------------------- result queue
  rlsw_pkg::rlsw_res_t q_mem [rlsw_pkg::Q_DEPTH];
  logic [1:0]          rd_ptr;
  logic [1:0]          wr_ptr;
  logic [2:0]          q_count;
  logic [2:0]          q_after_pop;
  logic                pop;

  assign pop         = (q_count != 3'd0) && !out_stall;
  assign q_after_pop = q_count - {2'd0, pop};
  // evaluate only when the whole set of actions fits behind what remains
  assign advance     = item_valid && ((q_after_pop + {1'b0, res_n}) <= 3'(rlsw_pkg::Q_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      q_count <= '0;
    end else begin
      rd_ptr  <= rd_ptr + {1'b0, pop};
      wr_ptr  <= advance ? wr_ptr + res_n : wr_ptr;
      q_count <= q_after_pop + (advance ? {1'b0, res_n} : 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < rlsw_pkg::MAX_RES; i++) begin
        if (2'(i) < res_n) begin
          q_mem[2'(wr_ptr + 2'(i))] <= res[i];
        end
      end
    end
  end

  assign out_valid      = q_count != 3'd0;
  assign action         = q_mem[rd_ptr].action;
  assign out_seq        = q_mem[rd_ptr].seq;
  assign out_ack        = q_mem[rd_ptr].ack;
  assign out_poll_final = q_mem[rd_ptr].poll_final;
  assign out_protocol   = q_mem[rd_ptr].protocol;
  assign out_length     = q_mem[rd_ptr].length;
  assign out_timeout    = q_mem[rd_ptr].timeout;
  assign last           = q_mem[rd_ptr].last;

endmodule

// ----- rtl/core/rlsw_checker.sv -----
`timescale 1ns / 1ps
`include "reliable_link_stop_and_wait_defines.svh"

module rlsw_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  action,
  input logic [15:0] out_length,
  input logic        last
);

  logic        act_ok;
  logic [20:0] head;

  assign act_ok = (action != rlsw_pkg::ACT_NONE) && (action <= rlsw_pkg::ACT_TOOBIG);
  assign head   = {action, last, out_length};

  // actions of one event are queued together, so a non-final one is followed at once
  `RLSW_ASSERT(a_burst_contiguous, out_valid && !out_stall && !last |=> out_valid, "burst broken")

  // every emitted action carries a real code
  `RLSW_ASSERT(a_action_code, out_valid |-> act_ok, "invalid action code")

  // a held result keeps its payload
  `RLSW_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(head), "stall moved")

  // reset empties the result queue
  `RLSW_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result pending after reset")

endmodule

bind reliable_link_stop_and_wait rlsw_checker u_rlsw_checker (.*);

// ----- tb/sv/reliable_link_stop_and_wait_test.sv -----
`timescale 1ns / 1ps

module reliable_link_stop_and_wait_test;
  import rlsw_pkg::*;

  localparam int unsigned INFO_LIMIT    = 1024;  // MAX_INFO_LEN of the instance
  localparam int          QUIET_LIMIT   = 600;   // cycles with no transaction before giving up
  localparam int          SETTLE_CYCLES = 12;    // covers the input register and the result queue
  // operation codes the block must ignore
  localparam logic [2:0]  OP_SPARE_A    = 3'd6;
  localparam logic [2:0]  OP_SPARE_B    = 3'd7;

  // one event transaction as the testbench sees it
  typedef struct packed {
    logic [2:0]  op;
    logic        sup;
    logic [1:0]  kind;
    logic        poll;
    logic [6:0]  seq;
    logic [6:0]  ack;
    logic [15:0] hlen;
    logic [15:0] cnt;
    logic [6:0]  tseq;
    logic [15:0] proto;
  } link_event_t;

  // link variables plus the two registers
  typedef struct packed {
    logic        up;
    logic [6:0]  vs;
    logic [6:0]  vr;
    logic [3:0]  retries;
    logic        busy;
    logic [15:0] hold_proto;
    logic [15:0] hold_len;
    logic [3:0]  max_retx;
    logic [15:0] tmo;
  } link_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [2:0]  operation       = '0;
  logic        hdr_supervisory = 1'b0;
  logic [1:0]  hdr_kind        = '0;
  logic        hdr_poll        = 1'b0;
  logic [6:0]  hdr_seq         = '0;
  logic [6:0]  hdr_ack         = '0;
  logic [15:0] hdr_length      = '0;
  logic [15:0] byte_count      = '0;
  logic [6:0]  timer_seq       = '0;
  logic [15:0] frame_protocol  = '0;

  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [3:0]  action;
  logic [6:0]  out_seq;
  logic [6:0]  out_ack;
  logic        out_poll_final;
  logic [15:0] out_protocol;
  logic [15:0] out_length;
  logic [15:0] out_timeout;
  logic        last;

  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [2:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;

  reliable_link_stop_and_wait #(
    .MAX_INFO_LEN(INFO_LIMIT)
  ) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .hdr_supervisory(hdr_supervisory), .hdr_kind(hdr_kind),
    .hdr_poll(hdr_poll), .hdr_seq(hdr_seq), .hdr_ack(hdr_ack), .hdr_length(hdr_length),
    .byte_count(byte_count), .timer_seq(timer_seq), .frame_protocol(frame_protocol),
    .out_valid(out_valid), .out_stall(out_stall),
    .action(action), .out_seq(out_seq), .out_ack(out_ack), .out_poll_final(out_poll_final),
    .out_protocol(out_protocol), .out_length(out_length), .out_timeout(out_timeout),
    .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  link_event_t queued_events[$];    // events waiting for the driver
  rlsw_res_t   pending_actions[$];  // predicted actions, oldest first
  rlsw_res_t   step_actions[$];     // scratch: actions of the event just evaluated

  link_state_t live_state;  // advanced at each accepted event transaction
  link_state_t plan_state;  // advanced as events are generated, to aim the stimulus

  int mismatches   = 0;
  int quiet_cycles = 0;

  // driver and monitor bookkeeping
  link_event_t cur_ev;
  bit          slot_full = 1'b0;
  int          tx_gap    = 0;
  int          tx_run    = 0;
  bit          tx_calm   = 1'b0;
  int          rx_gap    = 0;
  int          rx_run    = 0;
  bit          rx_calm   = 1'b0;
  rlsw_res_t   want;

  // ---------------------------------------------------------------------------
  // Action prediction
  // ---------------------------------------------------------------------------

  // At most three actions per event; anything beyond is dropped.
  task automatic push_action(input rlsw_act_t a, input logic [6:0] s, input logic [6:0] k,
                             input logic pf, input logic [15:0] p, input logic [15:0] l,
                             input logic [15:0] t);
    rlsw_res_t r;
    r.action     = a;
    r.seq        = s;
    r.ack        = k;
    r.poll_final = pf;
    r.protocol   = p;
    r.length     = l;
    r.timeout    = t;
    r.last       = 1'b0;
    if (step_actions.size() < MAX_RES) step_actions.push_back(r);
  endtask

  task automatic bounce_link(inout link_state_t st);
    push_action(ACT_CANCEL, '0, '0, 1'b0, '0, '0, '0);
    push_action(ACT_BOUNCE, '0, '0, 1'b0, '0, '0, '0);
    st.up   = 1'b0;
    st.busy = 1'b0;
  endtask

  // N(R) acknowledges the outstanding packet when N(R)-1 equals V(S), modulo 128
  task automatic take_ack(inout link_state_t st, input logic [6:0] nr);
    logic [6:0] nr_less;
    nr_less = nr - 7'd1;
    if (nr_less == st.vs) begin
      push_action(ACT_CANCEL, '0, '0, 1'b0, '0, '0, '0);
      push_action(ACT_RELEASE, '0, '0, 1'b0, '0, '0, '0);
      st.retries = '0;
      st.vs      = st.vs + 7'd1;
      st.busy    = 1'b0;
    end
  endtask

  task automatic send_info(inout link_state_t st, input logic [6:0] s);
    push_action(ACT_INFO, s, st.vr, 1'b1, st.hold_proto, st.hold_len + INFO_HDR_LEN, '0);
  endtask

  // Evaluates one event against st; the actions land in step_actions.
  task automatic link_actions(inout link_state_t st, input link_event_t ev);
    rlsw_res_t tail;
    step_actions.delete();
    case (ev.op)
      OP_CMD_RX: begin
        if (st.up) begin
          if (ev.cnt < SUP_HDR_LEN) begin
            bounce_link(st);
          end else if (ev.sup) begin
            take_ack(st, ev.ack);
            if (ev.poll) push_action(ACT_RR, '0, st.vr, 1'b1, '0, '0, '0);
          end else if (ev.cnt < INFO_HDR_LEN) begin
            bounce_link(st);
          end else if (ev.seq == st.vr) begin
            st.vr = st.vr + 7'd1;
            // truncated frame: V(R) moves but nothing is reported
            if (ev.hlen <= ev.cnt) begin
              push_action(ACT_DELIVER, '0, '0, 1'b0, ev.proto,
                          (ev.hlen >= INFO_HDR_LEN) ? ev.hlen - INFO_HDR_LEN : 16'd0, '0);
              push_action(ACT_RR, '0, st.vr, ev.poll, '0, '0, '0);
            end
          end else begin
            // out of sequence: no delivery, RR still goes out
            push_action(ACT_RR, '0, st.vr, ev.poll, '0, '0, '0);
          end
        end
      end
      OP_RSP_RX: begin
        if (st.up) begin
          if (ev.cnt < SUP_HDR_LEN) bounce_link(st);
          else if (ev.sup) take_ack(st, ev.ack);
        end
      end
      OP_TIMER: begin
        // honored with the link down too
        if (ev.tseq == st.vs) begin
          if (st.retries < RETRY_SAT) st.retries = st.retries + 4'd1;
          if (st.retries < st.max_retx) begin
            send_info(st, ev.tseq);
            push_action(ACT_START, ev.tseq, '0, 1'b0, '0, '0, st.tmo);
          end else begin
            bounce_link(st);
          end
        end
      end
      OP_SEND: begin
        if (!st.up || st.busy) begin
          push_action(ACT_REFUSED, '0, '0, 1'b0, '0, '0, '0);
        end else if (ev.cnt > INFO_LIMIT) begin
          push_action(ACT_TOOBIG, '0, '0, 1'b0, '0, '0, '0);
        end else begin
          st.busy       = 1'b1;
          st.hold_proto = ev.proto;
          st.hold_len   = ev.cnt;
          push_action(ACT_START, st.vs, '0, 1'b0, '0, '0, st.tmo);
          send_info(st, st.vs);
        end
      end
      OP_LINK_UP: begin
        st.up      = 1'b1;
        st.vs      = '0;
        st.vr      = '0;
        st.retries = '0;
        st.busy    = 1'b0;
        push_action(ACT_RELEASE, '0, '0, 1'b0, '0, '0, '0);
      end
      OP_LINK_DN: begin
        push_action(ACT_CANCEL, '0, '0, 1'b0, '0, '0, '0);
        push_action(ACT_RELEASE, '0, '0, 1'b0, '0, '0, '0);
        st.up   = 1'b0;
        st.busy = 1'b0;
      end
      default: ;  // spare codes do nothing
    endcase
    if (step_actions.size() > 0) begin
      tail      = step_actions[step_actions.size() - 1];
      tail.last = 1'b1;
      step_actions[step_actions.size() - 1] = tail;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic link_event_t random_event();
    link_event_t ev;
    ev.op    = 3'($urandom_range(0, 7));
    ev.sup   = 1'($urandom);
    ev.kind  = 2'($urandom);
    ev.poll  = 1'($urandom);
    ev.seq   = 7'($urandom);
    ev.ack   = 7'($urandom);
    ev.hlen  = 16'($urandom);
    ev.cnt   = 16'($urandom);
    ev.tseq  = 7'($urandom);
    ev.proto = 16'($urandom);
    return ev;
  endfunction

  function automatic link_event_t quiet_event(input logic [2:0] op);
    link_event_t ev;
    ev       = '0;
    ev.op    = op;
    ev.kind  = 2'($urandom);
    ev.cnt   = 16'd64;
    ev.proto = 16'($urandom);
    return ev;
  endfunction

  task automatic enqueue_event(input link_event_t ev);
    link_actions(plan_state, ev);
    queued_events.push_back(ev);
  endtask

  // Info command, mostly in sequence, with the length cases mixed in
  task automatic shape_info(inout link_event_t ev);
    ev.op  = OP_CMD_RX;
    ev.sup = 1'b0;
    if ($urandom_range(0, 9) != 0) ev.seq = plan_state.vr;
    ev.cnt = 16'($urandom_range(6, 2000));
    case ($urandom_range(0, 9))
      7:       ev.hlen = 16'($urandom_range(0, 5));
      8, 9:    ev.hlen = 16'(ev.cnt + $urandom_range(1, 100));
      default: ev.hlen = 16'($urandom_range(6, ev.cnt));
    endcase
  endtask

  // Mostly well-formed traffic aimed at the planned state. The long-session
  // form keeps the link up so that V(S) can run through the wrap.
  task automatic gen_events(input int count, input bit long_session);
    link_event_t ev;
    int          pick;
    int          send_share;
    send_share = long_session ? 85 : 50;
    repeat (count) begin
      ev   = random_event();
      pick = $urandom_range(0, 99);
      if (!long_session && pick < 12) begin
        // pure noise, spare operation codes included
      end else if (!plan_state.up) begin
        ev.op = (long_session || pick < 85) ? OP_LINK_UP : OP_SEND;
      end else if (!long_session && pick < 20) begin
        // layer down or a runt frame
        ev.op  = (pick < 16) ? OP_LINK_DN : ($urandom_range(0, 1) ? OP_CMD_RX : OP_RSP_RX);
        ev.cnt = 16'($urandom_range(0, 7));
      end else begin
        pick = $urandom_range(0, 99);
        if (plan_state.busy) begin
          if (pick < 65) begin
            ev.op  = OP_RSP_RX;
            ev.sup = 1'b1;
            ev.ack = plan_state.vs + 7'd1;
            ev.cnt = 16'($urandom_range(2, 65535));
          end else if (pick < 85) begin
            ev.op  = OP_CMD_RX;
            ev.sup = 1'b1;
            if ($urandom_range(0, 3) != 0) ev.ack = plan_state.vs + 7'd1;
            ev.cnt = 16'($urandom_range(2, 65535));
          end else if (pick < 93) begin
            ev.op   = OP_TIMER;
            ev.tseq = plan_state.vs;
          end else if (pick < 97) begin
            ev.op = OP_SEND;
          end else begin
            shape_info(ev);
          end
        end else begin
          if (pick < send_share) begin
            ev.op = OP_SEND;
            if ($urandom_range(0, 9) != 0) ev.cnt = 16'($urandom_range(0, INFO_LIMIT));
          end else begin
            case ($urandom_range(0, 2))
              0: shape_info(ev);
              1: begin
                ev.op  = OP_CMD_RX;
                ev.sup = 1'b1;
                ev.cnt = 16'($urandom_range(2, 65535));
              end
              default: ev.op = OP_TIMER;  // usually stale
            endcase
          end
        end
      end
      enqueue_event(ev);
    end
  endtask

  // Handshake-only events and every special case, in a known order
  task automatic directed_events();
    link_event_t ev;
    ev = quiet_event(OP_CMD_RX); ev.sup = 1'b1; ev.poll = 1'b1; ev.cnt = 16'hFFFF;
    enqueue_event(ev);                                   // link down: silent
    ev = quiet_event(OP_RSP_RX); ev.sup = 1'b1; enqueue_event(ev);
    enqueue_event(quiet_event(OP_SPARE_A));
    enqueue_event(quiet_event(OP_SPARE_B));
    enqueue_event(quiet_event(OP_SEND));                 // refused, link down
    ev = quiet_event(OP_TIMER); ev.tseq = plan_state.vs;
    enqueue_event(ev);                                   // expiry with link down
    enqueue_event(quiet_event(OP_LINK_UP));
    ev = quiet_event(OP_SEND); ev.cnt = 16'(INFO_LIMIT + 1); enqueue_event(ev);
    ev = quiet_event(OP_SEND); ev.cnt = 16'(INFO_LIMIT); ev.proto = 16'hFFFF; enqueue_event(ev);
    ev = quiet_event(OP_SEND); ev.cnt = 16'd5; enqueue_event(ev);   // busy
    ev = quiet_event(OP_TIMER); ev.tseq = 7'd5; enqueue_event(ev);  // stale
    ev = quiet_event(OP_TIMER); ev.tseq = plan_state.vs; enqueue_event(ev);
    ev = quiet_event(OP_RSP_RX); ev.sup = 1'b1; ev.ack = plan_state.vs + 7'd1;
    enqueue_event(ev);
    ev = quiet_event(OP_CMD_RX); ev.sup = 1'b1; ev.cnt = 16'd1; enqueue_event(ev);
    enqueue_event(quiet_event(OP_LINK_UP));
    ev = quiet_event(OP_CMD_RX); ev.cnt = 16'd5; enqueue_event(ev);  // short info frame
    enqueue_event(quiet_event(OP_LINK_UP));
    ev = quiet_event(OP_CMD_RX); ev.seq = plan_state.vr; ev.hlen = 16'd3; ev.cnt = 16'd10;
    ev.poll = 1'b1; enqueue_event(ev);                   // short header length
    ev = quiet_event(OP_CMD_RX); ev.seq = plan_state.vr + 7'd5; enqueue_event(ev);
    ev = quiet_event(OP_CMD_RX); ev.seq = plan_state.vr; ev.hlen = 16'd100; ev.cnt = 16'd50;
    enqueue_event(ev);                                   // truncated
    ev = quiet_event(OP_RSP_RX); ev.seq = plan_state.vr; enqueue_event(ev);  // info response
    ev = quiet_event(OP_CMD_RX); ev.seq = plan_state.vr; ev.hlen = 16'hFFFF;
    ev.cnt = 16'hFFFF; ev.proto = '0; enqueue_event(ev);
    ev = quiet_event(OP_CMD_RX); ev.sup = 1'b1; ev.poll = 1'b1; ev.ack = 7'd0;
    enqueue_event(ev);                                   // no ack, RR only
    ev = quiet_event(OP_SEND); ev.cnt = 16'd0; enqueue_event(ev);
    ev = quiet_event(OP_CMD_RX); ev.sup = 1'b1; ev.poll = 1'b1; ev.ack = plan_state.vs + 7'd1;
    enqueue_event(ev);                                   // three actions
    ev = quiet_event(OP_RSP_RX); ev.sup = 1'b1; ev.cnt = 16'd0; enqueue_event(ev);
    enqueue_event(quiet_event(OP_LINK_DN));
  endtask

  // ---------------------------------------------------------------------------
  // Configuration and phase control
  // ---------------------------------------------------------------------------

  // Setup then access; the write lands at the edge where pready is seen high.
  // Upper data bits are junk that the register must ignore.
  task automatic write_register(input logic idx, input logic [15:0] value);
    logic [31:0] data;
    data = $urandom;
    if (idx == REG_RETRY_LIMIT) data[3:0] = value[3:0];
    else data[15:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_RETRY_LIMIT) live_state.max_retx = data[3:0];
    else live_state.tmo = data[15:0];
  endtask

  // Sender holds off until every predicted action is back, then the pipeline
  // gets SETTLE_CYCLES more for events that report nothing.
  task automatic drain_and_settle();
    while (queued_events.size() != 0 || slot_full || pending_actions.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [3:0] max_retx, input logic [15:0] tmo,
                           input int count, input bit long_session);
    write_register(REG_RETRY_LIMIT, {12'd0, max_retx});
    write_register(REG_RETRANSMIT_TIMEOUT, tmo);
    plan_state = live_state;
    gen_events(count, long_session);
    drain_and_settle();
  endtask

  // Idle pattern: runs of back-to-back transactions alternate with runs of
  // transactions separated by random gaps.
  task automatic draw_gap(inout int run_left, inout bit calm, output int cycles);
    if (run_left == 0) begin
      calm     = ~calm;
      run_left = $urandom_range(8, 40);
    end
    run_left = run_left - 1;
    cycles   = calm ? 0 : $urandom_range(0, 11);
  endtask

  // ---------------------------------------------------------------------------
  // Event driver: one slot, refilled from queued_events after its gap
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        // transaction accepted: predict against the live state
        link_actions(live_state, cur_ev);
        foreach (step_actions[k]) pending_actions.push_back(step_actions[k]);
        slot_full = 1'b0;
        draw_gap(tx_run, tx_calm, tx_gap);
      end
      if (!slot_full) begin
        if (tx_gap > 0) begin
          tx_gap = tx_gap - 1;
        end else if (queued_events.size() != 0) begin
          cur_ev          = queued_events.pop_front();
          slot_full       = 1'b1;
          operation       <= cur_ev.op;
          hdr_supervisory <= cur_ev.sup;
          hdr_kind        <= cur_ev.kind;
          hdr_poll        <= cur_ev.poll;
          hdr_seq         <= cur_ev.seq;
          hdr_ack         <= cur_ev.ack;
          hdr_length      <= cur_ev.hlen;
          byte_count      <= cur_ev.cnt;
          timer_seq       <= cur_ev.tseq;
          frame_protocol  <= cur_ev.proto;
        end
      end
      in_valid <= slot_full;
    end
  end

  // ---------------------------------------------------------------------------
  // Action monitor and checker
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_actions.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected action, expected none actual %0h", $time, action);
        end else begin
          want = pending_actions.pop_front();
          check_field("action", 16'(want.action), 16'(action));
          check_field("out_seq", 16'(want.seq), 16'(out_seq));
          check_field("out_ack", 16'(want.ack), 16'(out_ack));
          check_field("out_poll_final", 16'(want.poll_final), 16'(out_poll_final));
          check_field("out_protocol", want.protocol, out_protocol);
          check_field("out_length", want.length, out_length);
          check_field("out_timeout", want.timeout, out_timeout);
          check_field("last", 16'(want.last), 16'(last));
        end
        draw_gap(rx_run, rx_calm, rx_gap);
      end else if (out_valid && rx_gap > 0) begin
        rx_gap = rx_gap - 1;
      end
      out_stall <= (rx_gap > 0);
    end
  end

  // Watchdog: any transaction or register access counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d actions still expected",
               $time, QUIET_LIMIT, pending_actions.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    live_state          = '0;
    live_state.max_retx = RST_RETRY_LIMIT;
    live_state.tmo      = RST_RETRANSMIT_TIMEOUT;
    plan_state          = live_state;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset values first: directed cases, then a short random run
    directed_events();
    gen_events(25, 1'b0);
    drain_and_settle();

    // a single transmission allowed: every expiry bounces
    run_phase(4'd1, 16'hFFFF, 25, 1'b0);
    // long session with the widest retry budget, V(S) wraps
    run_phase(4'd15, 16'd1, 320, 1'b1);
    run_phase(4'($urandom_range(1, 15)), 16'($urandom_range(1, 65535)), 25, 1'b0);
    run_phase(4'($urandom_range(2, 14)), 16'($urandom_range(1, 65535)), 25, 1'b0);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
